// ===== hdl/cat_pkg.sv =====
// Shared types and codes for the compacting array table.
package cat_pkg;

  localparam logic [1:0] MODE_FIND   = 2'd0;
  localparam logic [1:0] MODE_MODIFY = 2'd1;
  localparam logic [1:0] MODE_APPEND = 2'd2;
  localparam logic [1:0] MODE_REMOVE = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         position;
    logic signed [31:0] data_value;
  } cat_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         found_position;
    logic signed [31:0] new_value;
    logic signed [31:0] previous_value;
    logic [6:0]         entry_count;
  } cat_out_t;

  typedef struct packed {
    logic find;
    logic modify;
    logic append;
    logic remove;
  } cat_cmd_t;

endpackage

// ===== hdl/compacting_array_table.sv =====
// Compacting array table: a row of entry cells with a registered priority tree.
// Words are taken one at a time: a new word is accepted only once the result of
// the last is loaded into the output register, after the tree that resolves the
// lowest match and reads the indexed entry has settled.
// Reset: synchronous active-low rst_n empties the table; entry contents stay
// undefined until written.
module compacting_array_table #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cat_pkg::cat_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cat_pkg::cat_out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LV = $clog2(DEPTH);
  localparam int IW = LV;
  localparam int WW = (LV > 1) ? $clog2(LV) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]         mode_r;
  logic [5:0]         pos_r;
  logic signed [31:0] data_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [WW-1:0]      wait_r, wait_nxt;
  logic               out_valid_r;
  cat_pkg::cat_out_t  out_r, out_nxt;

  logic [CW+5:0]      pos_x, cnt_x;
  logic               in_range, not_full, exec;
  cat_pkg::cat_cmd_t  cmd;

  logic [31:0]        cell_val [DEPTH];
  logic               leaf_hit [DEPTH];
  logic [31:0]        leaf_val [DEPTH];
  logic               root_hit;
  logic [IW-1:0]      root_idx;
  logic [31:0]        root_val;
  logic [IW+5:0]      idx_x;
  logic [CW+6:0]      cnt_w;
  logic               load_out;

  assign pos_x    = {{CW{1'b0}}, pos_r};
  assign cnt_x    = {6'd0, count_r};
  assign in_range = pos_x < cnt_x;
  assign not_full = cnt_x < (CW+6)'(DEPTH);
  assign exec     = (state_r == S_EXEC);

  always_comb begin
    cmd.find   = exec && (mode_r == cat_pkg::MODE_FIND);
    cmd.modify = exec && (mode_r == cat_pkg::MODE_MODIFY) && in_range;
    cmd.append = exec && (mode_r == cat_pkg::MODE_APPEND) && not_full;
    cmd.remove = exec && (mode_r == cat_pkg::MODE_REMOVE) && in_range;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_val[i];
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    cat_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .exec       (exec),
      .cmd        (cmd),
      .pos        (pos_x),
      .cnt        (cnt_x),
      .data       (data_r),
      .nbr_val    (nbr),
      .val_o      (cell_val[i]),
      .leaf_hit_o (leaf_hit[i]),
      .leaf_val_o (leaf_val[i])
    );
  end

  cat_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk      (clk),
    .leaf_hit (leaf_hit),
    .leaf_val (leaf_val),
    .root_hit (root_hit),
    .root_idx (root_idx),
    .root_val (root_val)
  );

  assign idx_x    = {6'd0, root_idx};
  assign cnt_w    = {7'd0, count_r};
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    st_nxt    = st_r;
    wait_nxt  = wait_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_WAIT;
        wait_nxt  = '0;
        st_nxt    = cat_pkg::STAT_OK;
        case (mode_r)
          cat_pkg::MODE_MODIFY: begin
            if (!in_range) begin
              st_nxt = cat_pkg::STAT_RANGE;
            end
          end
          cat_pkg::MODE_APPEND: begin
            if (not_full) begin
              count_nxt = count_r + CW'(1);
            end else begin
              st_nxt = cat_pkg::STAT_FULL;
            end
          end
          cat_pkg::MODE_REMOVE: begin
            if (in_range) begin
              count_nxt = count_r - CW'(1);
            end else begin
              st_nxt = cat_pkg::STAT_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      S_WAIT: begin
        if (wait_r == WW'(LV - 1)) begin
          state_nxt = S_DONE;
        end else begin
          wait_nxt = wait_r + WW'(1);
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt                = '0;
    out_nxt.entry_count    = cnt_w[6:0];
    out_nxt.status         = st_r;
    if (mode_r == cat_pkg::MODE_FIND) begin
      if (root_hit) begin
        out_nxt.status         = cat_pkg::STAT_OK;
        out_nxt.found_position = idx_x[5:0];
      end else begin
        out_nxt.status = cat_pkg::STAT_NOTFOUND;
      end
    end
    if ((mode_r == cat_pkg::MODE_MODIFY) && (st_r == cat_pkg::STAT_OK)) begin
      out_nxt.new_value      = data_r;
      out_nxt.previous_value = root_val;
    end
    if ((mode_r == cat_pkg::MODE_REMOVE) && (st_r == cat_pkg::STAT_OK)) begin
      out_nxt.previous_value = root_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wait_r      <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wait_r  <= wait_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (in_valid && in_ready) begin
      mode_r <= in_data.mode;
      pos_r  <= in_data.position;
      data_r <= in_data.data_value;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/cat_cell.sv =====
// One table entry: write, shift from the upper neighbor, and leaf capture.
module cat_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic             clk,
  input  logic             exec,
  input  cat_pkg::cat_cmd_t cmd,
  input  logic [CW+5:0]    pos,
  input  logic [CW+5:0]    cnt,
  input  logic [31:0]      data,
  input  logic [31:0]      nbr_val,
  output logic [31:0]      val_o,
  output logic             leaf_hit_o,
  output logic [31:0]      leaf_val_o
);

  localparam logic [CW+5:0] ME    = (CW+6)'(IDX);
  localparam logic [CW+5:0] ME_P1 = (CW+6)'(IDX + 1);

  logic [31:0] value_r;
  logic [31:0] value_nxt;
  logic        leaf_hit_r;
  logic        leaf_hit_nxt;
  logic [31:0] leaf_val_r;

  always_comb begin
    value_nxt = value_r;
    if (cmd.modify && (ME == pos)) begin
      value_nxt = data;
    end
    if (cmd.append && (ME == cnt)) begin
      value_nxt = data;
    end
    if (cmd.remove && (ME >= pos) && (ME_P1 < cnt)) begin
      value_nxt = nbr_val;
    end
    if (cmd.find) begin
      leaf_hit_nxt = (value_r == data) && (ME < cnt);
    end else begin
      leaf_hit_nxt = (ME == pos);
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      value_r    <= value_nxt;
      leaf_hit_r <= leaf_hit_nxt;
      leaf_val_r <= value_r;
    end
  end

  assign val_o      = value_r;
  assign leaf_hit_o = leaf_hit_r;
  assign leaf_val_o = leaf_val_r;

endmodule

// ===== hdl/cat_tree.sv =====
// Registered priority tree: lowest hitting leaf with its index and value.
module cat_tree #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        leaf_hit [DEPTH],
  input  logic [31:0]                 leaf_val [DEPTH],
  output logic                        root_hit,
  output logic [$clog2(DEPTH)-1:0]    root_idx,
  output logic [31:0]                 root_val
);

  localparam int LV = $clog2(DEPTH);
  localparam int NP = 1 << LV;
  localparam int IW = LV;

  logic          lf_hit [NP];
  logic [31:0]   lf_val [NP];
  logic [IW-1:0] lf_idx [NP];

  logic          nd_hit_r [1:NP-1];
  logic [31:0]   nd_val_r [1:NP-1];
  logic [IW-1:0] nd_idx_r [1:NP-1];

  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < DEPTH) begin : g_real
      assign lf_hit[j] = leaf_hit[j];
      assign lf_val[j] = leaf_val[j];
    end else begin : g_pad
      assign lf_hit[j] = 1'b0;
      assign lf_val[j] = 32'd0;
    end
    assign lf_idx[j] = IW'(j);
  end

  for (genvar k = 1; k < NP; k++) begin : g_node
    logic          l_hit, r_hit;
    logic [31:0]   l_val, r_val;
    logic [IW-1:0] l_idx, r_idx;
    if (2 * k >= NP) begin : g_bottom
      assign l_hit = lf_hit[2*k-NP];
      assign l_val = lf_val[2*k-NP];
      assign l_idx = lf_idx[2*k-NP];
      assign r_hit = lf_hit[2*k+1-NP];
      assign r_val = lf_val[2*k+1-NP];
      assign r_idx = lf_idx[2*k+1-NP];
    end else begin : g_inner
      assign l_hit = nd_hit_r[2*k];
      assign l_val = nd_val_r[2*k];
      assign l_idx = nd_idx_r[2*k];
      assign r_hit = nd_hit_r[2*k+1];
      assign r_val = nd_val_r[2*k+1];
      assign r_idx = nd_idx_r[2*k+1];
    end
    always_ff @(posedge clk) begin
      if (l_hit) begin
        nd_hit_r[k] <= 1'b1;
        nd_val_r[k] <= l_val;
        nd_idx_r[k] <= l_idx;
      end else begin
        nd_hit_r[k] <= r_hit;
        nd_val_r[k] <= r_val;
        nd_idx_r[k] <= r_idx;
      end
    end
  end

  assign root_hit = nd_hit_r[1];
  assign root_idx = nd_idx_r[1];
  assign root_val = nd_val_r[1];

endmodule

// ===== bench/tb_compacting_array_table.sv =====
// Self-checking bench for compacting_array_table: find, modify, append and remove traffic.
module tb_compacting_array_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int TOTAL_WORDS = 1875;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cat_pkg::cat_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cat_pkg::cat_out_t out_data;

  compacting_array_table #(.DEPTH(SLOTS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cat_pkg::cat_in_t  pending_reqs[$];
  cat_pkg::cat_out_t expected_results[$];
  logic [31:0]       staged_words[$];

  logic [31:0] slot_words[SLOTS];
  int          slot_count = 0;

  int mismatches = 0;
  int accepted = 0;
  int n_ok = 0, n_range = 0, n_full = 0, n_notfound = 0, peak_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic cat_pkg::cat_out_t apply_request(input cat_pkg::cat_in_t req);
    cat_pkg::cat_out_t res;
    logic              hit;
    int                pos;
    res = '0;
    res.status = cat_pkg::STAT_OK;
    pos = int'(req.position);
    case (req.mode)
      cat_pkg::MODE_FIND: begin
        hit = 1'b0;
        for (int i = 0; i < slot_count; i++) begin
          if (!hit && slot_words[i] == req.data_value) begin
            hit = 1'b1;
            res.found_position = i[5:0];
          end
        end
        if (!hit) res.status = cat_pkg::STAT_NOTFOUND;
      end
      cat_pkg::MODE_MODIFY: begin
        if (pos >= slot_count) begin
          res.status = cat_pkg::STAT_RANGE;
        end else begin
          res.previous_value = slot_words[pos];
          slot_words[pos] = req.data_value;
          res.new_value = req.data_value;
        end
      end
      cat_pkg::MODE_APPEND: begin
        if (slot_count >= SLOTS) begin
          res.status = cat_pkg::STAT_FULL;
        end else begin
          slot_words[slot_count] = req.data_value;
          slot_count++;
        end
      end
      default: begin
        if (pos >= slot_count) begin
          res.status = cat_pkg::STAT_RANGE;
        end else begin
          res.previous_value = slot_words[pos];
          for (int i = pos; i + 1 < slot_count; i++) slot_words[i] = slot_words[i + 1];
          slot_count--;
        end
      end
    endcase
    res.entry_count = slot_count[6:0];
    return res;
  endfunction

  task automatic queue_req(input logic [1:0] m, input int p, input logic [31:0] v);
    cat_pkg::cat_in_t req;
    req.mode = m;
    req.position = p[5:0];
    req.data_value = v;
    pending_reqs.push_back(req);
    case (m)
      cat_pkg::MODE_MODIFY: if (p < staged_words.size()) staged_words[p] = v;
      cat_pkg::MODE_APPEND: if (staged_words.size() < SLOTS) staged_words.push_back(v);
      cat_pkg::MODE_REMOVE: if (p < staged_words.size()) staged_words.delete(p);
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && staged_words.size() > 0)
      return staged_words[$urandom_range(0, staged_words.size() - 1)];
    if (r < 6) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return 32'h0;
        default: return 32'($urandom_range(1, 7));
      endcase
    end
    return $urandom;
  endfunction

  function automatic int pick_position();
    int sz;
    sz = staged_words.size();
    if (sz > 0 && $urandom_range(0, 7) == 0) return sz - 1;
    if (sz > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, sz - 1);
    return $urandom_range(0, SLOTS - 1);
  endfunction

  task automatic build_stimulus();
    int          phase_kind;
    int          phase_left;
    int          r;
    logic [1:0]  m;
    queue_req(cat_pkg::MODE_FIND, 0, 32'h0);
    queue_req(cat_pkg::MODE_MODIFY, 0, 32'h1234_5678);
    queue_req(cat_pkg::MODE_REMOVE, 63, 32'hffff_ffff);
    queue_req(cat_pkg::MODE_APPEND, 0, 32'h8000_0000);
    queue_req(cat_pkg::MODE_APPEND, 0, 32'h7fff_ffff);
    queue_req(cat_pkg::MODE_APPEND, 0, 32'h0);
    queue_req(cat_pkg::MODE_APPEND, 0, 32'hffff_ffff);
    queue_req(cat_pkg::MODE_APPEND, 0, 32'h7fff_ffff);
    queue_req(cat_pkg::MODE_FIND, 0, 32'h7fff_ffff);
    queue_req(cat_pkg::MODE_FIND, 0, 32'hffff_ffff);
    queue_req(cat_pkg::MODE_FIND, 0, 32'h8000_0000);
    queue_req(cat_pkg::MODE_FIND, 0, 32'h0001_2345);
    queue_req(cat_pkg::MODE_MODIFY, 4, 32'hffff_ffff);
    queue_req(cat_pkg::MODE_MODIFY, 5, 32'h1);
    queue_req(cat_pkg::MODE_MODIFY, 63, 32'h0);
    queue_req(cat_pkg::MODE_FIND, 0, 32'hffff_ffff);
    queue_req(cat_pkg::MODE_REMOVE, 4, 32'h0);
    queue_req(cat_pkg::MODE_REMOVE, 0, 32'h0);
    queue_req(cat_pkg::MODE_FIND, 0, 32'h7fff_ffff);
    queue_req(cat_pkg::MODE_REMOVE, 4, 32'h0);
    queue_req(cat_pkg::MODE_APPEND, 63, 32'h5555_5555);
    queue_req(cat_pkg::MODE_APPEND, 42, 32'haaaa_aaaa);
    queue_req(cat_pkg::MODE_FIND, 21, 32'haaaa_aaaa);
    queue_req(cat_pkg::MODE_MODIFY, 0, 32'h8000_0000);
    phase_left = 0;
    phase_kind = 0;
    while (pending_reqs.size() < TOTAL_WORDS) begin
      if (phase_left == 0) begin
        phase_kind = $urandom_range(0, 3);
        phase_left = $urandom_range(40, 160);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      case (phase_kind)
        0: m = (r < 20) ? cat_pkg::MODE_FIND : (r < 35) ? cat_pkg::MODE_MODIFY :
               (r < 90) ? cat_pkg::MODE_APPEND : cat_pkg::MODE_REMOVE;
        1: m = (r < 20) ? cat_pkg::MODE_FIND : (r < 35) ? cat_pkg::MODE_MODIFY :
               (r < 45) ? cat_pkg::MODE_APPEND : cat_pkg::MODE_REMOVE;
        2: m = 2'(r / 25);
        default: m = 2'($urandom_range(0, 3));
      endcase
      if (phase_kind == 3 && $urandom_range(0, 1) == 0)
        queue_req(m, $urandom_range(0, SLOTS - 1), $urandom);
      else
        queue_req(m, pick_position(), pick_value());
    end
  endtask

  int tx_burst = 0;
  int tx_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(in_data));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (tx_burst > 0) tx_burst--;
          if (tx_burst == 0) begin
            tx_burst = $urandom_range(1, 40);
            tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int rx_cycle = 0;
  int rx_hold = 0;
  int rx_style = 0;
  int rx_left = 0;

  // hold off once for a long stretch so the input side backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 2500) rx_hold = 400;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_style = $urandom_range(0, 2);
          rx_left = $urandom_range(10, 120);
        end
        rx_left--;
        case (rx_style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cat_pkg::cat_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no request outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("found_position", 32'(want.found_position), 32'(out_data.found_position));
        check_field("new_value", want.new_value, out_data.new_value);
        check_field("previous_value", want.previous_value, out_data.previous_value);
        check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
        case (want.status)
          cat_pkg::STAT_OK:    n_ok++;
          cat_pkg::STAT_RANGE: n_range++;
          cat_pkg::STAT_FULL:  n_full++;
          default:             n_notfound++;
        endcase
        if (int'(want.entry_count) > peak_count) peak_count = int'(want.entry_count);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_compacting_array_table failed");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d requests checked: %0d ok, %0d out of range, %0d refused full, %0d not found",
             accepted, n_ok, n_range, n_full, n_notfound);
    $display("peak occupancy %0d of %0d entries", peak_count, SLOTS);
    if (mismatches == 0) begin
      $display("tb_compacting_array_table passed");
    end else begin
      $display("tb_compacting_array_table failed");
    end
    $finish;
  end

endmodule
